// ===== src/time_string_parser_assert.svh =====
// Assertion macros for the time string parser; clocked on clk, held off during reset.
`ifndef TIME_STRING_PARSER_ASSERT_SVH
`define TIME_STRING_PARSER_ASSERT_SVH

// Same-cycle implication.
`define TSP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TSP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/tsp_pkg.sv =====
// Shared types, constants and helpers for the time string parser.
`default_nettype none

package tsp_pkg;

	localparam int CHAR_W  = 8;
	localparam int PART_W  = 40;
	localparam int TOTAL_W = 48;
	localparam int VALUE_W = 48;
	localparam int FRAC_W  = 10;
	localparam int DIGS_W  = 2;
	localparam int ERR_W   = 2;

	// error flag bit positions
	localparam int ERR_SYN = 0;
	localparam int ERR_OVF = 1;

	localparam logic [PART_W-1:0]  PART_MAX  = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
	localparam logic [VALUE_W-1:0] POS_LIMIT = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic [VALUE_W-1:0] NEG_LIMIT = {1'b1, {(VALUE_W-1){1'b0}}};

	localparam logic [1:0] MAX_COLONS = 2'd2;
	localparam logic [DIGS_W-1:0] FRAC_KEEP = 2'd3;

	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;

	typedef enum logic [1:0] {
		PH_LEAD  = 2'd0,
		PH_PART  = 2'd1,
		PH_FRAC  = 2'd2,
		PH_TRAIL = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SYNTAX   = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	// end-of-string record from the parser
	typedef struct packed {
		logic                negative;
		logic [TOTAL_W-1:0]  total;
		logic [PART_W-1:0]   part;
		logic                fold;
		logic [FRAC_W-1:0]   frac_ms;
		logic [DIGS_W-1:0]   frac_digs;
		logic [ERR_W-1:0]    err;
	} fin_t;

	// folded seconds plus scaled fraction
	typedef struct packed {
		logic                negative;
		logic [TOTAL_W-1:0]  total;
		logic [FRAC_W-1:0]   frac_val;
		logic [ERR_W-1:0]    err;
	} sum_t;

	typedef struct packed {
		logic                ovf;
		logic [TOTAL_W-1:0]  total;
	} fold_t;

	// total*60 + part, saturating at the total's range
	function automatic fold_t fold_part(input logic [TOTAL_W-1:0] total,
	                                    input logic [PART_W-1:0] part);
		logic [TOTAL_W+6:0] t;
		fold_t r;
		t = ({7'b0, total} << 6) - ({7'b0, total} << 2)
		    + {{(TOTAL_W+7-PART_W){1'b0}}, part};
		if (t > {7'b0, TOTAL_MAX}) begin
			r.ovf   = 1'b1;
			r.total = TOTAL_MAX;
		end else begin
			r.ovf   = 1'b0;
			r.total = t[TOTAL_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/tsp_parse.sv =====
// Input register and per-character parser state machine.
`default_nettype none

module tsp_parse (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         char_valid,
	output logic                              char_stall,
	input  wire logic [tsp_pkg::CHAR_W-1:0]   character,
	input  wire logic                         last,
	output logic                              fin_valid,
	output tsp_pkg::fin_t                     fin,
	input  wire logic                         fin_ready
);

	logic                          valid_s1;
	logic [tsp_pkg::CHAR_W-1:0]    char_s1;
	logic                          last_s1;

	tsp_pkg::phase_t               phase_q, phase_n;
	logic                          neg_q, neg_n;
	logic [tsp_pkg::PART_W-1:0]    part_q, part_n;
	logic [tsp_pkg::TOTAL_W-1:0]   total_q, total_n;
	logic [1:0]                    colons_q, colons_n;
	logic [tsp_pkg::FRAC_W-1:0]    frac_q, frac_n;
	logic [tsp_pkg::DIGS_W-1:0]    digs_q, digs_n;
	logic [tsp_pkg::ERR_W-1:0]     err_q, err_n;

	logic                          fin_valid_s2;
	tsp_pkg::fin_t                 fin_s2, fin_n;

	logic                          fin_free, consume, s1_free;
	logic                          is_digit;
	logic [3:0]                    digit;
	logic [tsp_pkg::PART_W+3:0]    part_step;
	tsp_pkg::fold_t                fold_r;

	assign fin_free   = !fin_valid_s2 || fin_ready;
	assign consume    = valid_s1 && (!last_s1 || fin_free);
	assign s1_free    = !valid_s1 || consume;
	assign char_stall = !s1_free;
	assign fin_valid  = fin_valid_s2;
	assign fin        = fin_s2;

	assign is_digit = (char_s1 >= tsp_pkg::CH_ZERO) && (char_s1 <= tsp_pkg::CH_NINE);
	assign digit    = is_digit ? char_s1[3:0] : 4'd0;

	always_comb begin
		fold_r    = tsp_pkg::fold_part(total_q, part_q);
		part_step = ({4'b0, part_q} << 3) + ({4'b0, part_q} << 1)
		            + {{tsp_pkg::PART_W{1'b0}}, digit};
		phase_n  = phase_q;
		neg_n    = neg_q;
		part_n   = part_q;
		total_n  = total_q;
		colons_n = colons_q;
		frac_n   = frac_q;
		digs_n   = digs_q;
		err_n    = err_q;
		if (!err_q[tsp_pkg::ERR_SYN]) begin
			case (phase_q)
				tsp_pkg::PH_LEAD: begin
					if (char_s1 == tsp_pkg::CH_PLUS || char_s1 == tsp_pkg::CH_MINUS) begin
						neg_n   = (char_s1 == tsp_pkg::CH_MINUS);
						part_n  = '0;
						phase_n = tsp_pkg::PH_PART;
					end else if (is_digit) begin
						part_n  = {{(tsp_pkg::PART_W-4){1'b0}}, digit};
						phase_n = tsp_pkg::PH_PART;
					end else if (char_s1 != tsp_pkg::CH_SPACE) begin
						err_n[tsp_pkg::ERR_SYN] = 1'b1;
					end
				end
				tsp_pkg::PH_PART: begin
					if (is_digit) begin
						if (part_step > {4'b0, tsp_pkg::PART_MAX}) begin
							part_n = tsp_pkg::PART_MAX;
							err_n[tsp_pkg::ERR_OVF] = 1'b1;
						end else begin
							part_n = part_step[tsp_pkg::PART_W-1:0];
						end
					end else if (char_s1 == tsp_pkg::CH_DOT || char_s1 == tsp_pkg::CH_COMMA) begin
						total_n = fold_r.total;
						err_n[tsp_pkg::ERR_OVF] = err_q[tsp_pkg::ERR_OVF] | fold_r.ovf;
						part_n  = '0;
						frac_n  = '0;
						digs_n  = '0;
						phase_n = tsp_pkg::PH_FRAC;
					end else if (char_s1 == tsp_pkg::CH_COLON) begin
						if (colons_q >= tsp_pkg::MAX_COLONS) begin
							err_n[tsp_pkg::ERR_SYN] = 1'b1;
						end else begin
							total_n  = fold_r.total;
							err_n[tsp_pkg::ERR_OVF] = err_q[tsp_pkg::ERR_OVF] | fold_r.ovf;
							part_n   = '0;
							colons_n = colons_q + 2'd1;
						end
					end else if (char_s1 == tsp_pkg::CH_SPACE) begin
						total_n = fold_r.total;
						err_n[tsp_pkg::ERR_OVF] = err_q[tsp_pkg::ERR_OVF] | fold_r.ovf;
						part_n  = '0;
						phase_n = tsp_pkg::PH_TRAIL;
					end else begin
						err_n[tsp_pkg::ERR_SYN] = 1'b1;
					end
				end
				tsp_pkg::PH_FRAC: begin
					if (is_digit) begin
						if (digs_q < tsp_pkg::FRAC_KEEP) begin
							// at most 99 here, so ten bits hold the step
							frac_n = (frac_q << 3) + (frac_q << 1)
							         + {{(tsp_pkg::FRAC_W-4){1'b0}}, digit};
							digs_n = digs_q + 2'd1;
						end
					end else if (char_s1 == tsp_pkg::CH_SPACE) begin
						phase_n = tsp_pkg::PH_TRAIL;
					end else begin
						err_n[tsp_pkg::ERR_SYN] = 1'b1;
					end
				end
				default: begin
					if (char_s1 != tsp_pkg::CH_SPACE) begin
						err_n[tsp_pkg::ERR_SYN] = 1'b1;
					end
				end
			endcase
		end

		fin_n.negative  = neg_n;
		fin_n.total     = total_n;
		fin_n.part      = part_n;
		fin_n.fold      = !err_n[tsp_pkg::ERR_SYN] && (phase_n == tsp_pkg::PH_PART);
		fin_n.frac_ms   = frac_n;
		fin_n.frac_digs = digs_n;
		fin_n.err       = err_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			fin_valid_s2 <= 1'b0;
			phase_q      <= tsp_pkg::PH_LEAD;
			neg_q        <= 1'b0;
			part_q       <= '0;
			total_q      <= '0;
			colons_q     <= '0;
			frac_q       <= '0;
			digs_q       <= '0;
			err_q        <= '0;
		end else begin
			if (s1_free) begin
				valid_s1 <= char_valid;
			end
			if (fin_free) begin
				fin_valid_s2 <= consume && last_s1;
			end
			if (consume) begin
				if (last_s1) begin
					// string done: back to the start state
					phase_q  <= tsp_pkg::PH_LEAD;
					neg_q    <= 1'b0;
					part_q   <= '0;
					total_q  <= '0;
					colons_q <= '0;
					frac_q   <= '0;
					digs_q   <= '0;
					err_q    <= '0;
				end else begin
					phase_q  <= phase_n;
					neg_q    <= neg_n;
					part_q   <= part_n;
					total_q  <= total_n;
					colons_q <= colons_n;
					frac_q   <= frac_n;
					digs_q   <= digs_n;
					err_q    <= err_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free) begin
			char_s1 <= character;
			last_s1 <= last;
		end
		if (fin_free) begin
			fin_s2 <= fin_n;
		end
	end

endmodule

`default_nettype wire

// ===== src/tsp_fold.sv =====
// Final part fold and fraction scaling stage.
`default_nettype none

module tsp_fold (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            fin_valid,
	input  wire tsp_pkg::fin_t   fin,
	output logic                 fin_ready,
	output logic                 sum_valid,
	output tsp_pkg::sum_t        sum,
	input  wire logic            sum_ready
);

	logic                         sum_valid_s3;
	tsp_pkg::sum_t                sum_s3, sum_n;
	tsp_pkg::fold_t               fold_r;
	logic [tsp_pkg::FRAC_W-1:0]   f;

	assign fin_ready = !sum_valid_s3 || sum_ready;
	assign sum_valid = sum_valid_s3;
	assign sum       = sum_s3;

	always_comb begin
		fold_r = tsp_pkg::fold_part(fin.total, fin.part);
		f      = fin.frac_ms;
		sum_n.negative = fin.negative;
		sum_n.err      = fin.err;
		if (fin.fold) begin
			sum_n.total = fold_r.total;
			sum_n.err[tsp_pkg::ERR_OVF] = fin.err[tsp_pkg::ERR_OVF] | fold_r.ovf;
		end else begin
			sum_n.total = fin.total;
		end
		// kept digits to milliseconds; results stay below 1000
		case (fin.frac_digs)
			2'd1:    sum_n.frac_val = (f << 6) + (f << 5) + (f << 2);
			2'd2:    sum_n.frac_val = (f << 3) + (f << 1);
			default: sum_n.frac_val = f;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_valid_s3 <= 1'b0;
		end else if (fin_ready) begin
			sum_valid_s3 <= fin_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_ready) begin
			sum_s3 <= sum_n;
		end
	end

endmodule

`default_nettype wire

// ===== src/tsp_scale.sv =====
// Millisecond scaling, saturation, sign and result register.
`default_nettype none

module tsp_scale (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          sum_valid,
	input  wire tsp_pkg::sum_t                 sum,
	output logic                               sum_ready,
	output logic                               res_valid,
	input  wire logic                          res_stall,
	output logic [1:0]                         status,
	output logic signed [tsp_pkg::VALUE_W-1:0] value_ms
);

	localparam int MAG_W = tsp_pkg::TOTAL_W + 11;

	logic                               res_valid_q;
	tsp_pkg::status_t                   status_q, status_n;
	logic [tsp_pkg::VALUE_W-1:0]        value_q, value_n;
	logic [MAG_W-1:0]                   mag, limit;
	logic [tsp_pkg::VALUE_W-1:0]        sat;

	assign sum_ready = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;
	assign status    = status_q;
	assign value_ms  = value_q;

	always_comb begin
		// total*1000 = total*1024 - total*16 - total*8
		mag = ({11'b0, sum.total} << 10) - ({11'b0, sum.total} << 4)
		      - ({11'b0, sum.total} << 3)
		      + {{(MAG_W-tsp_pkg::FRAC_W){1'b0}}, sum.frac_val};
		limit = sum.negative ? {11'b0, tsp_pkg::NEG_LIMIT} : {11'b0, tsp_pkg::POS_LIMIT};
		if (sum.err[tsp_pkg::ERR_SYN]) begin
			sat      = '0;
			status_n = tsp_pkg::ST_SYNTAX;
			value_n  = '0;
		end else begin
			if (mag > limit) begin
				sat      = limit[tsp_pkg::VALUE_W-1:0];
				status_n = tsp_pkg::ST_OVERFLOW;
			end else begin
				sat      = mag[tsp_pkg::VALUE_W-1:0];
				status_n = sum.err[tsp_pkg::ERR_OVF] ? tsp_pkg::ST_OVERFLOW : tsp_pkg::ST_OK;
			end
			value_n = sum.negative ? ({tsp_pkg::VALUE_W{1'b0}} - sat) : sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (sum_ready) begin
			res_valid_q <= sum_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sum_ready) begin
			status_q <= status_n;
			value_q  <= value_n;
		end
	end

endmodule

`default_nettype wire

// ===== src/time_string_parser.sv =====
// Top level of the time string parser: pipeline of parser, fold and scale stages.
//
// Input channel (char_valid / char_stall / character / last): one ASCII byte
//   per item, last marks the final byte of a string [sign][[h:]m:]s[.frac].
//   Blanks around the value are skipped; ',' works as '.'.
// Result channel (res_valid / res_stall / status / value_ms): one item per
//   string, signed milliseconds and a status (ok, syntax error, overflow).
// Throughput: one character per cycle unless char_stall is high; strings may
//   follow back to back; parser state is cleared as the last character is taken.
// Path: the final character passes the input register, parser, final fold
//   and scale to milliseconds before res_valid rises.
// Stalls: each stage holds its item while the next is full, so characters
//   keep flowing while a result waits. char_stall only rises when a final
//   character meets a full pipeline behind a stalled result.
// Reset: arst_n clears all valids and the parser state at once; the block
//   takes characters as soon as reset is released.
`default_nettype none

module time_string_parser (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          char_valid,
	output logic                               char_stall,
	input  wire logic [tsp_pkg::CHAR_W-1:0]    character,
	input  wire logic                          last,
	output logic                               res_valid,
	input  wire logic                          res_stall,
	output logic [1:0]                         status,
	output logic signed [tsp_pkg::VALUE_W-1:0] value_ms
);

	`include "time_string_parser_assert.svh"

	// parser -> fold
	logic           fin_valid;
	tsp_pkg::fin_t  fin;
	logic           fin_ready;

	// fold -> scale
	logic           sum_valid;
	tsp_pkg::sum_t  sum;
	logic           sum_ready;

	// character-level state machine, input register and end-of-string record
	tsp_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.character  (character),
		.last       (last),
		.fin_valid  (fin_valid),
		.fin        (fin),
		.fin_ready  (fin_ready)
	);

	// folds the trailing part into whole seconds, scales the fraction
	tsp_fold u_fold (
		.clk       (clk),
		.arst_n    (arst_n),
		.fin_valid (fin_valid),
		.fin       (fin),
		.fin_ready (fin_ready),
		.sum_valid (sum_valid),
		.sum       (sum),
		.sum_ready (sum_ready)
	);

	// seconds to milliseconds, saturation, sign and result register
	tsp_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.sum_valid (sum_valid),
		.sum       (sum),
		.sum_ready (sum_ready),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.status    (status),
		.value_ms  (value_ms)
	);

	// input back-pressure only ever comes from a held result
	`TSP_ASSERT_NOW(a_stall_source, char_stall, res_valid && res_stall, "input stalled without a held result")

	// a syntax error always reports zero
	`TSP_ASSERT_NOW(a_syntax_zero, res_valid && status == tsp_pkg::ST_SYNTAX, value_ms == '0, "syntax result with non-zero value")

	// no final fold once a syntax error is flagged
	`TSP_ASSERT_NOW(a_no_fold_on_error, fin_valid && fin.err[tsp_pkg::ERR_SYN], !fin.fold, "final fold requested after syntax error")

	// an end-of-string record taken by the fold stage shows up there next cycle
	`TSP_ASSERT_NEXT(a_fold_advance, fin_valid && fin_ready, sum_valid, "fold stage lost an item")

endmodule

`default_nettype wire
